// ===== hdl/sbpd_pkg.sv =====
// Shared types and constants for the spectrum bar peak-hold draw unit.
package sbpd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HEIGHT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALL_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_TOP  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW_TOP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ROW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAR_PITCH  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAR_WIDTH  = 3'd6;

    localparam logic [7:0] RST_MAX_HEIGHT = 8'd230;
    localparam logic [7:0] RST_FALL_STEP  = 8'd5;
    localparam logic [7:0] RST_GREEN_TOP  = 8'd120;
    localparam logic [7:0] RST_YELLOW_TOP = 8'd190;
    localparam logic [9:0] RST_BASE_ROW   = 10'd230;
    localparam logic [3:0] RST_BAR_PITCH  = 4'd5;
    localparam logic [3:0] RST_BAR_WIDTH  = 4'd4;

    typedef enum logic [1:0] {
        COLOR_GREEN  = 2'd0,
        COLOR_YELLOW = 2'd1,
        COLOR_RED    = 2'd2,
        COLOR_BLACK  = 2'd3
    } t_color;

    typedef enum logic [1:0] {
        SEG_GREEN  = 2'd0,
        SEG_YELLOW = 2'd1,
        SEG_RED    = 2'd2
    } t_seg;

    typedef struct packed {
        logic [14:0] magnitude;
        logic        frame_start;
    } t_bin;

    typedef struct packed {
        logic [9:0] rect_x;
        logic [9:0] rect_y;
        logic [3:0] rect_width;
        logic [7:0] rect_height;
        logic [1:0] fill_color;
        logic [5:0] bar_number;
        logic [7:0] new_height;
        logic       last_command;
    } t_rect;

    typedef struct packed {
        logic [7:0] max_height;
        logic [7:0] fall_step;
        logic [7:0] green_top;
        logic [7:0] yellow_top;
        logic [9:0] base_row;
        logic [3:0] bar_pitch;
        logic [3:0] bar_width;
    } t_cfg;

    typedef struct packed {
        logic [7:0] bar;
        logic [7:0] old_h;
        logic [7:0] new_h;
    } t_bar_cmd;

endpackage

// ===== hdl/sbpd_front.sv =====
// Front part: bin grouping, averaging and peak-hold update of the bar store.
module sbpd_front #(
    parameter int BAR_COUNT    = 64,
    parameter int BINS_PER_BAR = 4,
    parameter int SKIPPED_BINS = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sbpd_pkg::t_bin    i_bin,
    input  logic [7:0]        i_max_height,
    input  logic [7:0]        i_fall_step,
    output logic              o_busy,
    output logic              o_cmd_valid,
    output sbpd_pkg::t_bar_cmd o_cmd
);
    import sbpd_pkg::*;

    localparam int BAR_W   = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
    localparam int SUB_W   = (BINS_PER_BAR > 1) ? $clog2(BINS_PER_BAR) : 1;
    localparam int END_POS = SKIPPED_BINS + BAR_COUNT * BINS_PER_BAR;
    localparam int POS_W   = $clog2(END_POS + 1);
    localparam int SUM_W   = 15 + $clog2(BINS_PER_BAR);
    localparam int SAT_SUM = 256 * BINS_PER_BAR;
    localparam int RECIP   = ((1 << 20) + BINS_PER_BAR - 1) / BINS_PER_BAR;

    logic [POS_W-1:0] r_pos;
    logic [SUB_W-1:0] r_sub;
    logic [BAR_W-1:0] r_bar;
    logic [SUM_W-1:0] r_sum;

    logic             r_a_valid;
    logic [BAR_W-1:0] r_a_bar;
    logic [SUM_W-1:0] r_a_sum;

    logic [7:0]           r_mem [BAR_COUNT];
    logic [BAR_COUNT-1:0] r_vld;
    logic [7:0]           r_rd_h;
    logic                 r_rd_vld;

    logic             r_w_valid;
    logic [BAR_W-1:0] r_w_bar;
    logic [7:0]       r_w_h;

    logic [POS_W-1:0] cur_pos;
    logic [SUB_W-1:0] cur_sub;
    logic [BAR_W-1:0] cur_bar;
    logic [SUM_W-1:0] cur_sum;
    logic [SUM_W-1:0] sum_new;
    logic             in_range;
    logic             group_done;
    logic [32:0]      prod;
    logic [7:0]       avg;
    logic [7:0]       avg_c;
    logic [7:0]       old_h;
    logic [7:0]       new_h;

    always_comb begin
        cur_pos    = i_bin.frame_start ? '0 : r_pos;
        cur_sub    = i_bin.frame_start ? '0 : r_sub;
        cur_bar    = i_bin.frame_start ? '0 : r_bar;
        cur_sum    = i_bin.frame_start ? '0 : r_sum;
        sum_new    = cur_sum + SUM_W'(i_bin.magnitude);
        in_range   = (cur_pos >= POS_W'(SKIPPED_BINS)) && (cur_pos < POS_W'(END_POS));
        group_done = in_range && (cur_sub == SUB_W'(BINS_PER_BAR - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sub <= '0;
            r_bar <= '0;
            r_sum <= '0;
        end else if (i_accept) begin
            r_pos <= (cur_pos < POS_W'(END_POS)) ? cur_pos + 1'b1 : cur_pos;
            if (group_done) begin
                r_sub <= '0;
                r_bar <= cur_bar + 1'b1;
                r_sum <= '0;
            end else if (in_range) begin
                r_sub <= cur_sub + 1'b1;
                r_bar <= cur_bar;
                r_sum <= sum_new;
            end else begin
                r_sub <= cur_sub;
                r_bar <= cur_bar;
                r_sum <= cur_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept && group_done;
            r_w_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && group_done) begin
            r_a_bar  <= cur_bar;
            r_a_sum  <= sum_new;
            r_rd_h   <= r_mem[cur_bar];
            r_rd_vld <= r_vld[cur_bar];
        end
        r_w_bar <= r_a_bar;
        r_w_h   <= new_h;
        if (r_a_valid) begin
            r_mem[r_a_bar] <= new_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_a_valid) begin
            r_vld[r_a_bar] <= 1'b1;
        end
    end

    always_comb begin
        prod  = {21'd0, r_a_sum[11:0]} * 33'(RECIP);
        avg   = (r_a_sum >= SUM_W'(SAT_SUM)) ? 8'hFF : prod[27:20];
        avg_c = (avg > i_max_height) ? i_max_height : avg;
        if (r_w_valid && (r_w_bar == r_a_bar)) begin
            old_h = r_w_h;
        end else begin
            old_h = r_rd_vld ? r_rd_h : 8'd0;
        end
        if (avg_c > old_h) begin
            new_h = avg_c;
        end else if (old_h > i_fall_step) begin
            new_h = old_h - i_fall_step;
        end else begin
            new_h = 8'd0;
        end
    end

    assign o_busy      = r_a_valid;
    assign o_cmd_valid = r_a_valid && (new_h != old_h);
    assign o_cmd.bar   = 8'(r_a_bar);
    assign o_cmd.old_h = old_h;
    assign o_cmd.new_h = new_h;

endmodule

// ===== hdl/sbpd_queue.sv =====
// Short queue of bar update requests between the front and back parts.
module sbpd_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  sbpd_pkg::t_bar_cmd        i_data,
    input  logic                      i_pop,
    output logic                      o_valid,
    output sbpd_pkg::t_bar_cmd        o_data,
    output logic [sbpd_pkg::QCNT_W-1:0] o_count
);
    import sbpd_pkg::*;

    t_bar_cmd          r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rp];
    assign o_count = r_count;

endmodule

// ===== hdl/sbpd_back.sv =====
// Back part: turns bar update requests into rectangle commands.
module sbpd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbpd_pkg::t_cfg     i_cfg,
    input  logic               i_head_valid,
    input  sbpd_pkg::t_bar_cmd i_head,
    output logic               o_head_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output sbpd_pkg::t_rect    o_rect
);
    import sbpd_pkg::*;

    t_seg   r_seg;
    t_seg   n_seg;
    logic   r_out_valid;
    t_rect  r_out;

    logic [7:0]  gt;
    logic [7:0]  yt;
    logic        rise;
    logic        has_y;
    logic        has_r;
    logic [11:0] x_full;
    logic [7:0]  h;
    logic [9:0]  y;
    t_color      color;
    logic        last;
    logic        advance;
    logic        take;
    t_rect       cmd;

    always_comb begin
        gt     = i_cfg.green_top;
        yt     = (i_cfg.yellow_top < gt) ? gt : i_cfg.yellow_top;
        rise   = i_head.new_h > i_head.old_h;
        has_y  = (i_head.new_h > gt) && (yt > gt);
        has_r  = i_head.new_h > yt;
        x_full = {4'd0, i_head.bar} * {8'd0, i_cfg.bar_pitch};
        n_seg  = SEG_GREEN;
        h      = 8'd0;
        y      = i_cfg.base_row;
        color  = COLOR_BLACK;
        last   = 1'b1;
        if (!rise) begin
            h     = i_head.old_h - i_head.new_h;
            y     = i_cfg.base_row - {2'b00, i_head.old_h};
            color = COLOR_BLACK;
        end else begin
            case (r_seg)
                SEG_GREEN: begin
                    h     = (i_head.new_h > gt) ? gt : i_head.new_h;
                    y     = i_cfg.base_row - {2'b00, h};
                    color = COLOR_GREEN;
                    last  = !has_y && !has_r;
                    n_seg = has_y ? SEG_YELLOW : SEG_RED;
                end
                SEG_YELLOW: begin
                    h     = ((i_head.new_h > yt) ? yt : i_head.new_h) - gt;
                    y     = i_cfg.base_row - {2'b00, gt} - {2'b00, h};
                    color = COLOR_YELLOW;
                    last  = !has_r;
                    n_seg = SEG_RED;
                end
                SEG_RED: begin
                    h     = i_head.new_h - yt;
                    y     = i_cfg.base_row - {2'b00, yt} - {2'b00, h};
                    color = COLOR_RED;
                end
                default: begin
                    h     = 8'd0;
                    color = COLOR_BLACK;
                end
            endcase
        end
        if (last) begin
            n_seg = SEG_GREEN;
        end

        cmd.rect_x       = x_full[9:0];
        cmd.rect_y       = y;
        cmd.rect_width   = i_cfg.bar_width;
        cmd.rect_height  = h;
        cmd.fill_color   = color;
        cmd.bar_number   = i_head.bar[5:0];
        cmd.new_height   = i_head.new_h;
        cmd.last_command = last;

        advance    = !r_out_valid || i_pop;
        take       = advance && i_head_valid;
        o_head_pop = take && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg       <= SEG_GREEN;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_seg <= n_seg;
            end
            if (advance) begin
                r_out_valid <= i_head_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= cmd;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_rect  = r_out;

endmodule

// ===== hdl/spectrum_bar_peak_hold_draw_unit.sv =====
// Top level of the spectrum bar peak-hold draw unit.
//
// Input side is a queue: an FFT bin (magnitude, frame_start) is taken on a
// clock edge with push high and full low, one bin per cycle while not full.
// Output side is a queue: while empty is low, the oldest rectangle command
// is on o_rect, and pop takes it. Each changed bar gives one to three
// commands, one per cycle while pop keeps up, in order green, yellow, red,
// or one black erase. Commands pass the update stage, queue and o_rect.
// Between the two halves sits a four-entry request queue; full rises when
// that queue plus the update stage in flight hold four requests, so a
// stalled receiver back-pressures the input after a few bar updates.
// The bar height memory is read when a group closes and written in the
// following cycle, with a bypass for back-to-back updates of the same bar.
// Registers are written over the cfg port, which is always ready.
// Reset is synchronous; it restores register defaults, sets every bar
// height to zero at once and restarts bin counting, with no clearing pass.
module spectrum_bar_peak_hold_draw_unit #(
    parameter int BAR_COUNT    = 64,
    parameter int BINS_PER_BAR = 4,
    parameter int SKIPPED_BINS = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  sbpd_pkg::t_bin                        i_bin,
    output logic                                  empty,
    input  logic                                  pop,
    output sbpd_pkg::t_rect                       o_rect,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sbpd_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [sbpd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import sbpd_pkg::*;

    t_cfg              r_cfg;
    logic              accept;
    logic              busy;
    logic              cmd_valid;
    t_bar_cmd          cmd;
    logic              head_valid;
    t_bar_cmd          head;
    logic              head_pop;
    logic [QCNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_height <= RST_MAX_HEIGHT;
            r_cfg.fall_step  <= RST_FALL_STEP;
            r_cfg.green_top  <= RST_GREEN_TOP;
            r_cfg.yellow_top <= RST_YELLOW_TOP;
            r_cfg.base_row   <= RST_BASE_ROW;
            r_cfg.bar_pitch  <= RST_BAR_PITCH;
            r_cfg.bar_width  <= RST_BAR_WIDTH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_HEIGHT: r_cfg.max_height <= i_cfg_data[7:0];
                CFG_FALL_STEP:  r_cfg.fall_step  <= i_cfg_data[7:0];
                CFG_GREEN_TOP:  r_cfg.green_top  <= i_cfg_data[7:0];
                CFG_YELLOW_TOP: r_cfg.yellow_top <= i_cfg_data[7:0];
                CFG_BASE_ROW:   r_cfg.base_row   <= i_cfg_data;
                CFG_BAR_PITCH:  r_cfg.bar_pitch  <= i_cfg_data[3:0];
                CFG_BAR_WIDTH:  r_cfg.bar_width  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign full   = ({1'b0, q_count} + (QCNT_W + 1)'(busy)) >= (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept = push && !full;

    sbpd_front #(
        .BAR_COUNT   (BAR_COUNT),
        .BINS_PER_BAR(BINS_PER_BAR),
        .SKIPPED_BINS(SKIPPED_BINS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_bin       (i_bin),
        .i_max_height(r_cfg.max_height),
        .i_fall_step (r_cfg.fall_step),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    sbpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_valid),
        .i_data (cmd),
        .i_pop  (head_pop),
        .o_valid(head_valid),
        .o_data (head),
        .o_count(q_count)
    );

    sbpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head_valid(head_valid),
        .i_head      (head),
        .o_head_pop  (head_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_rect      (o_rect)
    );

endmodule

// ===== hdl/sbpd_checker.sv =====
// Port-level checks for the spectrum bar peak-hold draw unit and their binding.
module sbpd_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            empty,
    input logic            pop,
    input sbpd_pkg::t_rect o_rect
);
    import sbpd_pkg::*;

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("Result queue not empty after reset.");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rect)))
        else $error("Waiting result changed before it was taken.");

    a_single_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_rect.fill_color == COLOR_BLACK || o_rect.fill_color == COLOR_RED))
        |-> o_rect.last_command)
        else $error("Erase or red segment is not the final request of its bar.");

    a_green_only_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rect.fill_color == COLOR_GREEN && o_rect.last_command)
        |-> (o_rect.rect_height == o_rect.new_height))
        else $error("Lone green segment does not match the new bar height.");

endmodule

bind spectrum_bar_peak_hold_draw_unit sbpd_checker u_sbpd_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .empty  (empty),
    .pop    (pop),
    .o_rect (o_rect)
);
